>>> hw/rtl/tdc_pkg.sv
// ----------------------------------------------------------------------------
// tdc_pkg
// Types and constants shared by the time-of-day clock with countdown.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int TOTAL_WIDTH    = 32;
  localparam int CD_WIDTH       = 16;
  localparam int INTERVAL_WIDTH = 10;

  localparam logic [INTERVAL_WIDTH-1:0] INTERVAL_RESET = INTERVAL_WIDTH'(1);

  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_START  = 3'd1;
  localparam logic [2:0] KIND_PAUSE  = 3'd2;
  localparam logic [2:0] KIND_RESUME = 3'd3;
  localparam logic [2:0] KIND_CANCEL = 3'd4;

  localparam logic [10:0] MS_PER_SEC   = 11'd1000;
  localparam logic [10:0] MS_PER_2SEC  = 11'd2000;
  localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
  localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
  localparam logic [5:0]  HOUR_PER_DAY = 6'd24;

  typedef struct packed {
    logic [2:0]          kind;
    logic [CD_WIDTH-1:0] duration;
  } in_item_t;

  typedef struct packed {
    logic [TOTAL_WIDTH-1:0] elapsed_ms;
    logic [9:0]             millis;
    logic [5:0]             seconds;
    logic [5:0]             minutes;
    logic [4:0]             hours;
    logic [7:0]             days;
    logic [CD_WIDTH-1:0]    time_left;
    logic                   countdown_running;
    logic                   time_up;
  } out_item_t;

  typedef struct packed {
    logic [9:0] ms;
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [7:0] day;
  } cal_t;

endpackage

>>> hw/rtl/time_of_day_clock_with_countdown.sv
// ----------------------------------------------------------------------------
// time_of_day_clock_with_countdown
// Millisecond time-of-day clock with day count and a countdown timer.
// ----------------------------------------------------------------------------
// channel   signals                        direction
// in        in_valid, in_stall, in_data    command item in
// out       out_valid, out_stall, out_data clock and countdown state out
// cfg       cfg_write, cfg_data            tick interval write
//
// one item per cycle while the output is not stalled; the result is registered
// after the input register and one pass through decode and carry chain
// synchronous reset clears all counters; interval resets to 1 ms
// an output stall holds the result and backs up into in_stall only
// when the input register is also full
module time_of_day_clock_with_countdown (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tdc_pkg::INTERVAL_WIDTH-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  tdc_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tdc_pkg::out_item_t                 out_data
);

  logic              busy;
  logic              cmd_valid;
  tdc_pkg::in_item_t cmd;

  tdc_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  tdc_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> hw/rtl/tdc_in_stage.sv
// ----------------------------------------------------------------------------
// tdc_in_stage
// Input register; holds an item while the result side is stalled.
// ----------------------------------------------------------------------------
module tdc_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  tdc_pkg::in_item_t in_data,
  input  logic              busy,
  output logic              cmd_valid,
  output tdc_pkg::in_item_t cmd
);

  assign in_stall = cmd_valid && busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!in_stall) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cmd <= in_data;
    end
  end

endmodule

>>> hw/rtl/tdc_calendar.sv
// ----------------------------------------------------------------------------
// tdc_calendar
// Carry chain from milliseconds up through days for one tick.
// ----------------------------------------------------------------------------
module tdc_calendar (
  input  tdc_pkg::cal_t                       cal,
  input  logic [tdc_pkg::INTERVAL_WIDTH-1:0]  delta,
  output tdc_pkg::cal_t                       cal_next
);

  logic [10:0] ms_sum;
  logic [1:0]  ms_carry;
  logic [6:0]  sec_sum;
  logic        sec_carry;
  logic [6:0]  min_sum;
  logic        min_carry;
  logic [5:0]  hour_sum;
  logic        hour_carry;

  always_comb begin
    ms_sum = 11'(cal.ms) + 11'(delta);
    if (ms_sum >= tdc_pkg::MS_PER_2SEC) begin
      cal_next.ms = 10'(ms_sum - tdc_pkg::MS_PER_2SEC);
      ms_carry    = 2'd2;
    end else if (ms_sum >= tdc_pkg::MS_PER_SEC) begin
      cal_next.ms = 10'(ms_sum - tdc_pkg::MS_PER_SEC);
      ms_carry    = 2'd1;
    end else begin
      cal_next.ms = ms_sum[9:0];
      ms_carry    = 2'd0;
    end

    sec_sum = 7'(cal.sec) + 7'(ms_carry);
    sec_carry = sec_sum >= tdc_pkg::SEC_PER_MIN;
    cal_next.sec = sec_carry ? 6'(sec_sum - tdc_pkg::SEC_PER_MIN) : sec_sum[5:0];

    min_sum = 7'(cal.min) + 7'(sec_carry);
    min_carry = min_sum >= tdc_pkg::MIN_PER_HOUR;
    cal_next.min = min_carry ? 6'(min_sum - tdc_pkg::MIN_PER_HOUR) : min_sum[5:0];

    hour_sum = 6'(cal.hour) + 6'(min_carry);
    hour_carry = hour_sum >= tdc_pkg::HOUR_PER_DAY;
    cal_next.hour = hour_carry ? 5'(hour_sum - tdc_pkg::HOUR_PER_DAY) : hour_sum[4:0];

    cal_next.day = cal.day + 8'(hour_carry);
  end

endmodule

>>> hw/rtl/tdc_core.sv
// ----------------------------------------------------------------------------
// tdc_core
// Clock and countdown state, command decode and the result register.
// ----------------------------------------------------------------------------
module tdc_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tdc_pkg::INTERVAL_WIDTH-1:0] cfg_data,
  input  logic                               cmd_valid,
  input  tdc_pkg::in_item_t                  cmd,
  output logic                               busy,
  output logic                               out_valid,
  input  logic                               out_stall,
  output tdc_pkg::out_item_t                 out_data
);

  logic [tdc_pkg::INTERVAL_WIDTH-1:0] interval;
  logic [tdc_pkg::TOTAL_WIDTH-1:0]    total_count;
  logic [tdc_pkg::TOTAL_WIDTH-1:0]    total_count_next;
  tdc_pkg::cal_t                      cal;
  tdc_pkg::cal_t                      cal_tick;
  tdc_pkg::cal_t                      cal_next;
  logic [tdc_pkg::CD_WIDTH-1:0]       remaining;
  logic [tdc_pkg::CD_WIDTH-1:0]       remaining_next;
  logic                               running;
  logic                               running_next;
  logic                               fire;
  logic                               tick;

  assign busy = out_valid && out_stall;
  assign fire = cmd_valid && !busy;
  assign tick = (cmd.kind == tdc_pkg::KIND_TICK) && (interval != '0);

  tdc_calendar u_calendar (
    .cal      (cal),
    .delta    (interval),
    .cal_next (cal_tick)
  );

  always_comb begin
    total_count_next = total_count;
    cal_next         = cal;
    remaining_next   = remaining;
    running_next     = running;
    case (cmd.kind)
      tdc_pkg::KIND_TICK: begin
        if (tick) begin
          total_count_next = total_count + tdc_pkg::TOTAL_WIDTH'(interval);
          cal_next         = cal_tick;
          if (running) begin
            if (remaining > tdc_pkg::CD_WIDTH'(interval)) begin
              remaining_next = remaining - tdc_pkg::CD_WIDTH'(interval);
            end else begin
              remaining_next = '0;
              running_next   = 1'b0;
            end
          end
        end
      end
      tdc_pkg::KIND_START: begin
        remaining_next = cmd.duration;
        running_next   = 1'b1;
      end
      tdc_pkg::KIND_PAUSE: begin
        running_next = 1'b0;
      end
      tdc_pkg::KIND_RESUME: begin
        running_next = 1'b1;
      end
      tdc_pkg::KIND_CANCEL: begin
        remaining_next = '0;
        running_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= tdc_pkg::INTERVAL_RESET;
    end else if (cfg_write) begin
      interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_count <= '0;
      cal         <= '0;
      remaining   <= '0;
      running     <= 1'b0;
    end else if (fire) begin
      total_count <= total_count_next;
      cal         <= cal_next;
      remaining   <= remaining_next;
      running     <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.elapsed_ms        <= total_count_next;
      out_data.millis            <= cal_next.ms;
      out_data.seconds           <= cal_next.sec;
      out_data.minutes           <= cal_next.min;
      out_data.hours             <= cal_next.hour;
      out_data.days              <= cal_next.day;
      out_data.time_left         <= remaining_next;
      out_data.countdown_running <= running_next;
      out_data.time_up           <= (remaining_next == '0);
    end
  end

endmodule

>>> hw/rtl/tdc_checker.sv
// ----------------------------------------------------------------------------
// tdc_checker
// Port-level checks on the clock block, bound to the top level.
// ----------------------------------------------------------------------------
module tdc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input tdc_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_time_up: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.time_up == (out_data.time_left == '0))
    else $error("time_up disagrees with time_left");

  a_cal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.millis < 10'd1000 && out_data.seconds < 6'd60 &&
                  out_data.minutes < 6'd60 && out_data.hours < 5'd24)
    else $error("calendar field out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind time_of_day_clock_with_countdown tdc_checker u_tdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> dv/tb_time_of_day_clock_with_countdown.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_time_of_day_clock_with_countdown
// Self-checking bench for the time-of-day clock with countdown. A driver
// feeds command items from a queue, an in-bench clock model predicts each
// reading, and a monitor checks the readings in order. Phases cover several
// tick intervals (0, 1, 1000, 1023 and random ones), a tick run that carries
// seconds into minutes, and random command streams with sender gaps,
// receiver stalls, a long output hold-off and a sender pause.
// ----------------------------------------------------------------------------
module tb_time_of_day_clock_with_countdown;

  localparam logic [2:0] KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID   = 3'd6;
  localparam logic [2:0] KIND_UNUSED_LAST  = 3'd7;
  localparam int         HOLD_CYCLES       = 250;
  localparam int         FAST_TICKS        = 120;
  localparam int         PHASE_ITEMS       = 100;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               cfg_write = 1'b0;
  logic [tdc_pkg::INTERVAL_WIDTH-1:0] cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  tdc_pkg::in_item_t                  in_data = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  tdc_pkg::out_item_t                 out_data;

  // clock model state
  logic [tdc_pkg::TOTAL_WIDTH-1:0]    model_total;
  tdc_pkg::cal_t                      model_cal;
  logic [tdc_pkg::CD_WIDTH-1:0]       model_left;
  logic                               model_running;
  logic [tdc_pkg::INTERVAL_WIDTH-1:0] model_interval;

  tdc_pkg::in_item_t  pending_cmds[$];
  tdc_pkg::out_item_t expected_readings[$];

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic send_hold = 1'b0;
  logic hold_go = 1'b0;
  int   hold_left = 0;
  int   accepted_count = 0;
  int   checked_count = 0;
  int   mismatch_count = 0;

  time_of_day_clock_with_countdown uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void advance_clock(logic [tdc_pkg::INTERVAL_WIDTH-1:0] step);
    int unsigned carry;
    if (step != 0) begin
      if (model_running) begin
        if (model_left > step) begin
          model_left = model_left - step;
        end else begin
          model_left = '0;
          model_running = 1'b0;
        end
      end
      model_total = model_total + step;
      carry = model_cal.ms + step;
      model_cal.ms = 10'(carry % tdc_pkg::MS_PER_SEC);
      carry = model_cal.sec + carry / tdc_pkg::MS_PER_SEC;
      model_cal.sec = 6'(carry % tdc_pkg::SEC_PER_MIN);
      carry = model_cal.min + carry / tdc_pkg::SEC_PER_MIN;
      model_cal.min = 6'(carry % tdc_pkg::MIN_PER_HOUR);
      carry = model_cal.hour + carry / tdc_pkg::MIN_PER_HOUR;
      model_cal.hour = 5'(carry % tdc_pkg::HOUR_PER_DAY);
      model_cal.day = model_cal.day + 8'(carry / tdc_pkg::HOUR_PER_DAY);
    end
  endfunction

  function automatic tdc_pkg::out_item_t apply_command(tdc_pkg::in_item_t cmd);
    tdc_pkg::out_item_t r;
    case (cmd.kind)
      tdc_pkg::KIND_TICK: advance_clock(model_interval);
      tdc_pkg::KIND_START: begin
        model_left = cmd.duration;
        model_running = 1'b1;
      end
      tdc_pkg::KIND_PAUSE: model_running = 1'b0;
      tdc_pkg::KIND_RESUME: model_running = 1'b1;
      tdc_pkg::KIND_CANCEL: begin
        model_left = '0;
        model_running = 1'b0;
      end
      default: ;
    endcase
    r.elapsed_ms = model_total;
    r.millis = model_cal.ms;
    r.seconds = model_cal.sec;
    r.minutes = model_cal.min;
    r.hours = model_cal.hour;
    r.days = model_cal.day;
    r.time_left = model_left;
    r.countdown_running = model_running;
    r.time_up = (model_left == 0);
    return r;
  endfunction

  function automatic tdc_pkg::in_item_t random_command();
    tdc_pkg::in_item_t c;
    int unsigned       pick;
    pick = $urandom_range(99);
    c.duration = tdc_pkg::CD_WIDTH'($urandom);
    if (pick < 55) begin
      c.kind = tdc_pkg::KIND_TICK;
    end else if (pick < 70) begin
      c.kind = tdc_pkg::KIND_START;
      if ($urandom_range(1) == 0) c.duration = tdc_pkg::CD_WIDTH'($urandom_range(4000));
    end else if (pick < 78) begin
      c.kind = tdc_pkg::KIND_PAUSE;
    end else if (pick < 86) begin
      c.kind = tdc_pkg::KIND_RESUME;
    end else if (pick < 94) begin
      c.kind = tdc_pkg::KIND_CANCEL;
    end else begin
      c.kind = 3'($urandom_range(KIND_UNUSED_LAST, KIND_UNUSED_FIRST));
    end
    return c;
  endfunction

  task automatic push_cmd(logic [2:0] kind, logic [tdc_pkg::CD_WIDTH-1:0] duration);
    tdc_pkg::in_item_t c;
    c.kind = kind;
    c.duration = duration;
    pending_cmds.push_back(c);
  endtask

  task automatic wait_drain();
    while (pending_cmds.size() != 0 || in_valid || expected_readings.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_interval(logic [tdc_pkg::INTERVAL_WIDTH-1:0] value);
    wait_drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    model_interval = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(logic [tdc_pkg::INTERVAL_WIDTH-1:0] interval, int send_pct,
                              int recv_pct);
    set_interval(interval);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) pending_cmds.push_back(random_command());
  endtask

  task automatic flag_mismatch(string field, longint unsigned got,
                               longint unsigned want);
    $display("mismatch on reading %0d: %s got %0d expected %0d",
             checked_count, field, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(string field, longint unsigned got,
                             longint unsigned want);
    if (got != want) flag_mismatch(field, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(apply_command(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_cmds.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    tdc_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          flag_mismatch("unexpected reading elapsed_ms", out_data.elapsed_ms, 0);
        end else begin
          want = expected_readings.pop_front();
          check_field("elapsed_ms", out_data.elapsed_ms, want.elapsed_ms);
          check_field("millis", out_data.millis, want.millis);
          check_field("seconds", out_data.seconds, want.seconds);
          check_field("minutes", out_data.minutes, want.minutes);
          check_field("hours", out_data.hours, want.hours);
          check_field("days", out_data.days, want.days);
          check_field("time_left", out_data.time_left, want.time_left);
          check_field("countdown_running", out_data.countdown_running,
                      want.countdown_running);
          check_field("time_up", out_data.time_up, want.time_up);
          checked_count++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    model_total = '0;
    model_cal = '0;
    model_left = '0;
    model_running = 1'b0;
    model_interval = tdc_pkg::INTERVAL_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: countdown commands at the reset interval
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_START, '1);
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_PAUSE, '0);
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_RESUME, '0);
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_CANCEL, '1);
    push_cmd(tdc_pkg::KIND_START, '0);
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_START, tdc_pkg::CD_WIDTH'(5));
    push_cmd(tdc_pkg::KIND_CANCEL, '0);
    push_cmd(tdc_pkg::KIND_RESUME, '0);
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(KIND_UNUSED_FIRST, '1);
    push_cmd(KIND_UNUSED_MID, '1);
    push_cmd(KIND_UNUSED_LAST, '1);

    // zero interval: ticks leave everything alone
    set_interval('0);
    push_cmd(tdc_pkg::KIND_START, tdc_pkg::CD_WIDTH'(100));
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_TICK, '0);

    // largest interval against countdowns just around it
    set_interval('1);
    push_cmd(tdc_pkg::KIND_START, tdc_pkg::CD_WIDTH'(1000));
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_START, tdc_pkg::CD_WIDTH'(1024));
    push_cmd(tdc_pkg::KIND_TICK, '0);
    push_cmd(tdc_pkg::KIND_START, tdc_pkg::CD_WIDTH'(1023));
    push_cmd(tdc_pkg::KIND_TICK, '0);

    // tick run carrying seconds into minutes
    wait_drain();
    push_cmd(tdc_pkg::KIND_START, '1);
    repeat (FAST_TICKS) push_cmd(tdc_pkg::KIND_TICK, '0);

    random_phase(tdc_pkg::INTERVAL_WIDTH'($urandom_range(1000, 1)), 0, 0);
    random_phase(tdc_pkg::INTERVAL_WIDTH'(1000), 68, 0);
    random_phase(tdc_pkg::INTERVAL_WIDTH'($urandom_range(1023)), 0, 68);
    random_phase('1, 8, 8);

    // output held off while the sender keeps offering items
    random_phase(tdc_pkg::INTERVAL_WIDTH'($urandom_range(999, 1)), 0, 0);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;

    // sender pause in mid-stream until all readings are back
    random_phase(tdc_pkg::INTERVAL_RESET, 8, 8);
    while (pending_cmds.size() > PHASE_ITEMS / 2) @(posedge clk);
    @(posedge clk);
    send_hold <= 1'b1;
    @(posedge clk);
    while (in_valid || expected_readings.size() != 0) @(posedge clk);
    @(posedge clk);
    send_hold <= 1'b0;

    random_phase(tdc_pkg::INTERVAL_WIDTH'($urandom_range(1023)), 68, 68);

    wait_drain();
    repeat (10) @(posedge clk);
    $display("summary: %0d command items, %0d readings checked, %0d mismatches",
             accepted_count, checked_count, mismatch_count);
    $display("summary: intervals 0..1023 ms, all countdown commands, clock at day %0d %0d:%0d",
             model_cal.day, model_cal.hour, model_cal.min);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
